FILE: rtl/core/nnsa_pkg.sv
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared codes and field widths of the nearest-neighbor source address block.
// ----------------------------------------------------------------------------
package nnsa_pkg;

   // request fields
   localparam int BATCH_W    = 8;
   localparam int CHAN_W     = 12;
   localparam int OCOORD_W   = 12;
   localparam int REQ_DATA_W = 48;   // 44 bits of fields, padded to bytes

   // response fields
   localparam int SRC_W      = 12;
   localparam int SRC_IDX_W  = 32;
   localparam int RSP_DATA_W = 64;   // 57 bits of fields, padded to bytes
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * SRC_W + SRC_IDX_W + 1);

   // configuration port
   localparam int DIM_W       = 13;
   localparam int SCALE_W     = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INPUT_HEIGHT  = 3'd0,
      REG_INPUT_WIDTH   = 3'd1,
      REG_CHANNEL_COUNT = 3'd2,
      REG_COORD_MODE    = 3'd3,
      REG_LAYOUT_NHWC   = 3'd4,
      REG_ROW_SCALE     = 3'd5,
      REG_COL_SCALE     = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_FLOOR       = 2'd0,
      MODE_ALIGN_ROUND = 2'd1,
      MODE_HALF_PIXEL  = 2'd2,
      MODE_ONNX_HALF   = 2'd3
   } coord_mode_type;

endpackage

FILE: rtl/core/nearest_neighbor_source_address.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_source_address
// Maps an output coordinate of a nearest-neighbor resize to its source row,
// column and flat element index (NHWC or NCHW), with an index overflow flag.
// ----------------------------------------------------------------------------
// One coordinate enters per clock while the response side takes data; its
// result leaves through a five-stage pipeline: the row and column scale
// multiplies, the coordinate rounding and clamp, then two multiply-accumulate
// stages and a final add that build the flat index. Each stage holds its item
// while the next one is full and cannot advance, so bubbles close up and
// throughput stays at one transfer per cycle as long as the response side takes
// data. Configuration registers must only be written while no transfer is in flight.
// ----------------------------------------------------------------------------
module nearest_neighbor_source_address #(
   parameter int COORD_BITS      = 12,
   parameter int INDEX_BITS      = 32,
   parameter int SCALE_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // batch_idx[7:0], chan_idx[19:8], out_row[31:20], out_col[43:32]
   input  logic [nnsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // src_row[11:0], src_col[23:12], src_index[55:24], index_overflow[56]
   output logic [nnsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [nnsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import nnsa_pkg::*;

   localparam int DW  = COORD_BITS + 1;                  // effective dimension
   localparam int CW  = (DW > DIM_W) ? DW : DIM_W;       // dimension compare width
   localparam int MW  = OCOORD_W + 1;                    // 2o or 2o+1
   localparam int PW  = MW + SCALE_W;                    // scaled coordinate
   localparam int A1W = BATCH_W + DW + 1;
   localparam int M1W = A1W + DW;
   localparam int A2W = M1W + 1;
   localparam int M2W = A2W + DW;
   localparam int IW  = M2W + 1;
   localparam int WW  = ((IW > INDEX_BITS) ? IW : INDEX_BITS) + 1;

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0]   height_ff, width_ff, chans_ff;
   logic [1:0]         mode_ff;
   logic               nhwc_ff;
   logic [SCALE_W-1:0] row_scale_ff, col_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= DIM_W'(1);
         width_ff     <= DIM_W'(1);
         chans_ff     <= DIM_W'(1);
         mode_ff      <= MODE_FLOOR;
         nhwc_ff      <= 1'b0;
         row_scale_ff <= SCALE_W'(1) << SCALE_FRAC_BITS;
         col_scale_ff <= SCALE_W'(1) << SCALE_FRAC_BITS;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_INPUT_HEIGHT:  height_ff    <= csr_wdata[DIM_W-1:0];
            REG_INPUT_WIDTH:   width_ff     <= csr_wdata[DIM_W-1:0];
            REG_CHANNEL_COUNT: chans_ff     <= csr_wdata[DIM_W-1:0];
            REG_COORD_MODE:    mode_ff      <= csr_wdata[1:0];
            REG_LAYOUT_NHWC:   nhwc_ff      <= csr_wdata[0];
            REG_ROW_SCALE:     row_scale_ff <= csr_wdata[SCALE_W-1:0];
            REG_COL_SCALE:     col_scale_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as 1, anything above 2^COORD_BITS saturates
   function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [CW-1:0] dx;
      logic [CW-1:0] cap;
      dx  = CW'(d);
      cap = CW'(1) << COORD_BITS;
      if (d == '0)
         return DW'(1);
      else if (dx > cap)
         return DW'(cap);
      else
         return DW'(dx);
   endfunction

   logic [DW-1:0]         dim_h, dim_w, dim_c;
   logic [COORD_BITS-1:0] hm1, wm1;

   assign dim_h = eff_dim(height_ff);
   assign dim_w = eff_dim(width_ff);
   assign dim_c = eff_dim(chans_ff);
   assign hm1   = COORD_BITS'(dim_h - DW'(1));
   assign wm1   = COORD_BITS'(dim_w - DW'(1));

   // product holds 2*o*s (modes 0,1) or (2o+1)*s (modes 2,3), shift by F+1
   function automatic logic [COORD_BITS-1:0] map_coord(input logic [PW-1:0] p,
                                                       input logic [1:0] mode,
                                                       input logic [COORD_BITS-1:0] dm1);
      logic [PW:0] half;
      logic [PW:0] s;
      logic [PW:0] v;
      half = (PW+1)'(1) << SCALE_FRAC_BITS;
      case (mode)
         MODE_ALIGN_ROUND: s = {1'b0, p} + half;
         MODE_ONNX_HALF:   s = ({1'b0, p} < half) ? '0 : ({1'b0, p} - half);
         default:          s = {1'b0, p};
      endcase
      v = s >> (SCALE_FRAC_BITS + 1);
      if (v > (PW+1)'(dm1))
         return dm1;
      else
         return COORD_BITS'(v);
   endfunction

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: scale multiplies ----------------
   logic [BATCH_W-1:0]  req_batch;
   logic [CHAN_W-1:0]   req_chan;
   logic [OCOORD_W-1:0] req_row, req_col;

   assign req_batch = req_tdata[BATCH_W-1:0];
   assign req_chan  = req_tdata[BATCH_W +: CHAN_W];
   assign req_row   = req_tdata[BATCH_W+CHAN_W +: OCOORD_W];
   assign req_col   = req_tdata[BATCH_W+CHAN_W+OCOORD_W +: OCOORD_W];

   logic [PW-1:0]         prow_ff, pcol_ff, prow_in, pcol_in;
   logic [BATCH_W+DW-1:0] p0_ff, p0_in;
   logic [CHAN_W-1:0]     c1_ff;

   assign prow_in = PW'({req_row, mode_ff[1]}) * PW'(row_scale_ff);
   assign pcol_in = PW'({req_col, mode_ff[1]}) * PW'(col_scale_ff);
   assign p0_in   = (BATCH_W+DW)'(req_batch) * (BATCH_W+DW)'(nhwc_ff ? dim_h : dim_c);

   always_ff @(posedge clock) begin
      if (en1) begin
         prow_ff <= prow_in;
         pcol_ff <= pcol_in;
         p0_ff   <= p0_in;
         c1_ff   <= req_chan;
      end
   end

   // ---------------- stage 2: round, clamp, first accumulate ----------------
   logic [COORD_BITS-1:0] r2_ff, q2_ff, r2_in, q2_in;
   logic [A1W-1:0]        a1_ff, a1_in;
   logic [CHAN_W-1:0]     c2_ff;

   assign r2_in = map_coord(prow_ff, mode_ff, hm1);
   assign q2_in = map_coord(pcol_ff, mode_ff, wm1);
   assign a1_in = A1W'(p0_ff) + (nhwc_ff ? A1W'(r2_in) : A1W'(c1_ff));

   always_ff @(posedge clock) begin
      if (en2) begin
         r2_ff <= r2_in;
         q2_ff <= q2_in;
         a1_ff <= a1_in;
         c2_ff <= c1_ff;
      end
   end

   // ---------------- stage 3: second multiply ----------------
   logic [M1W-1:0]        m1_ff, m1_in;
   logic [COORD_BITS-1:0] r3_ff, q3_ff;
   logic [CHAN_W-1:0]     c3_ff;

   assign m1_in = M1W'(a1_ff) * M1W'(nhwc_ff ? dim_w : dim_h);

   always_ff @(posedge clock) begin
      if (en3) begin
         m1_ff <= m1_in;
         r3_ff <= r2_ff;
         q3_ff <= q2_ff;
         c3_ff <= c2_ff;
      end
   end

   // ---------------- stage 4: add and third multiply ----------------
   logic [A2W-1:0]        a2;
   logic [M2W-1:0]        m2_ff, m2_in;
   logic [COORD_BITS-1:0] r4_ff, q4_ff;
   logic [CHAN_W-1:0]     c4_ff;

   assign a2    = A2W'(m1_ff) + (nhwc_ff ? A2W'(q3_ff) : A2W'(r3_ff));
   assign m2_in = M2W'(a2) * M2W'(nhwc_ff ? dim_c : dim_w);

   always_ff @(posedge clock) begin
      if (en4) begin
         m2_ff <= m2_in;
         r4_ff <= r3_ff;
         q4_ff <= q3_ff;
         c4_ff <= c3_ff;
      end
   end

   // ---------------- stage 5: final add, overflow, output register ----------------
   logic [IW-1:0]        idx;
   logic [WW-1:0]        idx_w, idx_lo;
   logic [SRC_W-1:0]     row_ff, col_ff;
   logic [SRC_IDX_W-1:0] index_ff, index_in;
   logic                 ovf_ff, ovf_in;

   assign idx      = IW'(m2_ff) + (nhwc_ff ? IW'(c4_ff) : IW'(q4_ff));
   assign idx_w    = WW'(idx);
   assign idx_lo   = idx_w & ((WW'(1) << INDEX_BITS) - WW'(1));
   assign ovf_in   = (idx_w >> INDEX_BITS) != '0;
   assign index_in = SRC_IDX_W'(idx_lo);

   always_ff @(posedge clock) begin
      if (en5) begin
         row_ff   <= SRC_W'(r4_ff);
         col_ff   <= SRC_W'(q4_ff);
         index_ff <= index_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), ovf_ff, index_ff, col_ff, row_ff};

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted transfer did not enter stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp_tvalid && !rsp_tready) |=> (v4_ff && rsp_tvalid))
      else $error("stalled pipeline dropped an item");

endmodule
